@@ rtl/etsa_pkg.sv @@
package etsa_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_MAP_MODE   = 3'd0;
	localparam logic [2:0] REG_GAIN       = 3'd1;
	localparam logic [2:0] REG_DECAY      = 3'd2;
	localparam logic [2:0] REG_SPAN       = 3'd3;
	localparam logic [2:0] REG_AXIS_MAX   = 3'd4;
	localparam logic [2:0] REG_AXIS_MIN   = 3'd5;

	// map_mode codes
	localparam logic MODE_POSITION = 1'b0;
	localparam logic MODE_VELOCITY = 1'b1;

	// register reset values
	localparam logic [6:0]  GAIN_RST     = 7'd4;
	localparam logic [6:0]  DECAY_RST    = 7'd8;
	localparam logic [15:0] SPAN_RST     = 16'd256;
	localparam logic [6:0]  AXIS_MAX_RST = 7'd127;
	localparam logic [7:0]  AXIS_MIN_RST = 8'h81;  // -127

	// scaled residue: 15-bit magnitude times 7-bit full scale
	localparam int DIV_BITS = 22;

	// sequencer states
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ABS   = 7'b0000010,
		ST_MOD   = 7'b0000100,
		ST_FOLD  = 7'b0001000,
		ST_SCALE = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

endpackage

@@ rtl/encoder_to_stick_axis.sv @@
// Channel    | Signals                                   | Direction
// item       | item_valid, item_ready, delta[15:0]       | in
// result     | result_valid, result_ready, axis_value[7:0] | out
// cfg        | cfg_valid, cfg_ready, cfg_index[2:0], cfg_data[15:0] | in
//
// Velocity mode: the add/clamp result is registered in the idle cycle of the item
// transaction and goes to the output register from the finish step. Position mode:
// an abs step, a bit-serial remainder loop of POSITION_WIDTH steps, fold and scale
// steps and a 22-step quotient loop come before the finish step (all skipped when
// the span is below two); a new item is taken only once the block is back in idle.
// One item in flight; the next item is taken while the last result waits.
// arst_n clears control state, registers to their reset values, accumulator and
// held axis to zero. A stalled result only holds the finish step.
module encoder_to_stick_axis #(
	parameter int POSITION_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [15:0] delta,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  axis_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int P     = POSITION_WIDTH;
	localparam int CNT_N = (P > etsa_pkg::DIV_BITS) ? P : etsa_pkg::DIV_BITS;
	localparam int CNT_W = $clog2(CNT_N);
	localparam int DB    = etsa_pkg::DIV_BITS;

	etsa_pkg::state_t state_q;

	logic        mode_q;
	logic [6:0]  gain_q;
	logic [6:0]  decay_q;
	logic [15:0] span_q;
	logic [6:0]  amax_q;
	logic [7:0]  amin_q;

	logic [7:0]       stick_q;
	logic [P-1:0]     accum_q;
	logic [P-1:0]     mag_q;     // remainder loop dividend shift register
	logic             neg_q;     // sign of the accumulator
	logic             sign_q;    // sign of the folded residue
	logic [15:0]      rem_q;
	logic [DB-1:0]    div_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       res_q;
	logic [7:0]       out_q;
	logic             out_valid_q;

	logic [14:0] half;
	logic        accept;
	logic        finish;

	assign half       = span_q[15:1];
	assign accept     = item_valid && item_ready;
	assign item_ready = (state_q == etsa_pkg::ST_IDLE);
	assign finish     = (state_q == etsa_pkg::ST_FIN) && (!out_valid_q || result_ready);
	assign cfg_ready  = 1'b1;
	assign result_valid = out_valid_q;
	assign axis_value   = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= etsa_pkg::MODE_POSITION;
			gain_q  <= etsa_pkg::GAIN_RST;
			decay_q <= etsa_pkg::DECAY_RST;
			span_q  <= etsa_pkg::SPAN_RST;
			amax_q  <= etsa_pkg::AXIS_MAX_RST;
			amin_q  <= etsa_pkg::AXIS_MIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				etsa_pkg::REG_MAP_MODE: mode_q  <= cfg_data[0];
				etsa_pkg::REG_GAIN:     gain_q  <= cfg_data[6:0];
				etsa_pkg::REG_DECAY:    decay_q <= cfg_data[6:0];
				etsa_pkg::REG_SPAN:     span_q  <= cfg_data;
				etsa_pkg::REG_AXIS_MAX: amax_q  <= cfg_data[6:0];
				etsa_pkg::REG_AXIS_MIN: amin_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// velocity mode: add delta * gain with clamp, or decay toward zero
	logic [23:0] vel_prod;
	logic [24:0] vel_sum;
	logic [8:0]  dec_t;
	logic [7:0]  vel_res;

	always_comb begin
		vel_prod = {{8{delta[15]}}, delta} * {17'b0, gain_q};
		vel_sum  = {{17{stick_q[7]}}, stick_q} + {vel_prod[23], vel_prod};
		dec_t    = 9'd0;
		vel_res  = stick_q;
		if (delta != 16'd0) begin
			if ($signed(vel_sum) > $signed({18'b0, amax_q}))
				vel_res = {1'b0, amax_q};
			else if ($signed(vel_sum) < $signed({{17{amin_q[7]}}, amin_q}))
				vel_res = amin_q;
			else
				vel_res = vel_sum[7:0];
		end else if ($signed(stick_q) > 8'sd0) begin
			dec_t   = {stick_q[7], stick_q} - {2'b0, decay_q};
			vel_res = dec_t[8] ? 8'd0 : dec_t[7:0];
		end else if ($signed(stick_q) < 8'sd0) begin
			dec_t   = {stick_q[7], stick_q} + {2'b0, decay_q};
			vel_res = (!dec_t[8] && dec_t != 9'd0) ? 8'd0 : dec_t[7:0];
		end
	end

	// remainder step: one accumulator bit into the running residue
	logic [16:0] mod_t;
	logic        mod_ge;
	logic [16:0] mod_sub;

	assign mod_t   = {rem_q, mag_q[P-1]};
	assign mod_ge  = (mod_t >= {1'b0, span_q});
	assign mod_sub = mod_t - {1'b0, span_q};

	// fold and scale
	logic [15:0] fold_r;
	logic        fold_hi;
	logic [15:0] fold_mag;
	logic [21:0] scale_prod;

	always_comb begin
		fold_r     = (neg_q && rem_q != 16'd0) ? (span_q - rem_q) : rem_q;
		fold_hi    = (rem_q > {1'b0, half});
		fold_mag   = fold_hi ? (span_q - rem_q) : rem_q;
		scale_prod = {7'b0, fold_mag[14:0]} * {15'b0, amax_q};
	end

	// quotient step: one dividend bit against half the span
	logic [15:0] div_t;
	logic        div_ge;
	logic [DB-1:0] div_n;
	logic [7:0]  quo;

	assign div_t  = {rem_q[14:0], div_q[DB-1]};
	assign div_ge = (div_t >= {1'b0, half});
	assign div_n  = {div_q[DB-2:0], div_ge};
	assign quo    = {1'b0, div_n[6:0]};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= etsa_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			stick_q     <= 8'd0;
			accum_q     <= '0;
		end else begin
			// result register: loaded at finish, cleared when taken
			if (finish)
				out_valid_q <= 1'b1;
			else if (result_valid && result_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				etsa_pkg::ST_IDLE: begin
					if (accept) begin
						if (mode_q == etsa_pkg::MODE_VELOCITY) begin
							state_q <= etsa_pkg::ST_FIN;
						end else begin
							accum_q <= accum_q + {{(P-16){delta[15]}}, delta};
							state_q <= (half == 15'd0) ? etsa_pkg::ST_FIN : etsa_pkg::ST_ABS;
						end
					end
				end
				etsa_pkg::ST_ABS:   state_q <= etsa_pkg::ST_MOD;
				etsa_pkg::ST_MOD: begin
					if (cnt_q == CNT_W'(P - 1))
						state_q <= etsa_pkg::ST_FOLD;
				end
				etsa_pkg::ST_FOLD:  state_q <= etsa_pkg::ST_SCALE;
				etsa_pkg::ST_SCALE: state_q <= etsa_pkg::ST_DIV;
				etsa_pkg::ST_DIV: begin
					if (cnt_q == CNT_W'(DB - 1))
						state_q <= etsa_pkg::ST_FIN;
				end
				etsa_pkg::ST_FIN: begin
					if (finish) begin
						stick_q <= res_q;
						state_q <= etsa_pkg::ST_IDLE;
					end
				end
				default: state_q <= etsa_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			etsa_pkg::ST_IDLE: begin
				res_q <= (mode_q == etsa_pkg::MODE_VELOCITY) ? vel_res : 8'd0;
			end
			etsa_pkg::ST_ABS: begin
				neg_q <= accum_q[P-1];
				mag_q <= accum_q[P-1] ? (~accum_q + P'(1)) : accum_q;
				rem_q <= 16'd0;
				cnt_q <= '0;
			end
			etsa_pkg::ST_MOD: begin
				rem_q <= mod_ge ? mod_sub[15:0] : mod_t[15:0];
				mag_q <= {mag_q[P-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			etsa_pkg::ST_FOLD: begin
				rem_q <= fold_r;
			end
			etsa_pkg::ST_SCALE: begin
				sign_q <= fold_hi;
				div_q  <= scale_prod;
				rem_q  <= 16'd0;
				cnt_q  <= '0;
			end
			etsa_pkg::ST_DIV: begin
				rem_q <= div_ge ? (div_t - {1'b0, half}) : div_t;
				div_q <= div_n;
				cnt_q <= cnt_q + CNT_W'(1);
				res_q <= sign_q ? (8'd0 - quo) : quo;
			end
			etsa_pkg::ST_FIN: begin
				if (finish)
					out_q <= res_q;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/etsa_checker.sv @@
module etsa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [7:0]  axis_value,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// a waiting result holds its value
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(axis_value))
		else $error("result changed while stalled");

	// an accepted item closes the input on the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input reopened right after a transaction");

	// a new result appears only from the finish step, never from idle
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!item_ready))
		else $error("result appeared without an item in work");

	// configuration transactions are never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind encoder_to_stick_axis etsa_checker u_etsa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.axis_value   (axis_value),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

@@ sim/tb_encoder_to_stick_axis.sv @@
`timescale 1ns / 1ps

module tb_encoder_to_stick_axis;

	localparam int POS_W       = 32;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_HOLD   = 400;
	localparam int DRAIN_WAIT  = 64;
	localparam int N_PHASES    = 10;
	localparam int PHASE_ITEMS = 123;
	// indexes past the last register, must be ignored
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [15:0] delta = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [7:0]  axis_value;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predicted block settings and state
	logic              cur_mode     = etsa_pkg::MODE_POSITION;
	logic [6:0]        cur_gain     = etsa_pkg::GAIN_RST;
	logic [6:0]        cur_decay    = etsa_pkg::DECAY_RST;
	logic [15:0]       cur_span     = etsa_pkg::SPAN_RST;
	logic [6:0]        cur_axis_max = etsa_pkg::AXIS_MAX_RST;
	logic signed [7:0] cur_axis_min = etsa_pkg::AXIS_MIN_RST;
	logic signed [7:0] held_axis    = '0;
	logic [POS_W-1:0]  position     = '0;

	logic [15:0]       delta_queue[$];
	logic signed [7:0] expected_axis[$];
	logic signed [7:0] want_axis;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int mismatches    = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int cycles        = 0;

	// long receiver hold-off, started by toggling hold_req
	logic hold_req  = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;

	encoder_to_stick_axis #(
		.POSITION_WIDTH(POS_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.delta       (delta),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.axis_value  (axis_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// axis value for one tick; advances held axis and, in position mode, the accumulator
	function automatic logic signed [7:0] next_axis(input logic signed [15:0] d);
		int     sum;
		int     gain;
		int     decay;
		int     lim_hi;
		int     lim_lo;
		longint pos;
		longint span_l;
		longint half;
		longint rem;
		gain   = cur_gain;
		decay  = cur_decay;
		lim_hi = cur_axis_max;
		lim_lo = cur_axis_min;
		if (cur_mode == etsa_pkg::MODE_VELOCITY) begin
			sum = held_axis;
			if (d != 0) begin
				sum = sum + int'(d) * gain;
				// upper clamp wins when the limits cross
				if (sum > lim_hi)
					sum = lim_hi;
				else if (sum < lim_lo)
					sum = lim_lo;
			end else if (sum > 0) begin
				sum = sum - decay;
				if (sum < 0)
					sum = 0;
			end else if (sum < 0) begin
				sum = sum + decay;
				if (sum > 0)
					sum = 0;
			end
		end else begin
			position = position + {{(POS_W-16){d[15]}}, d};
			pos    = longint'($signed(position));
			span_l = longint'(cur_span);
			half   = span_l / 2;
			if (half <= 0) begin
				sum = 0;
			end else begin
				// fold residue into (-span/2, span/2], then scale toward zero
				rem = pos % span_l;
				if (rem < 0)
					rem = rem + span_l;
				if (rem > half)
					rem = rem - span_l;
				sum = int'((rem * longint'(lim_hi)) / half);
			end
		end
		held_axis = 8'(sum);
		return 8'(sum);
	endfunction

	function automatic int pick(input int lo, input int hi, input int ph);
		if (ph == 0)
			return lo;
		if (ph == 1)
			return hi;
		if ($urandom_range(3) == 0)
			return ($urandom_range(1) != 0) ? hi : lo;
		return int'($urandom_range(hi, lo));
	endfunction

	// one register write transaction; settings follow at the handshake
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			etsa_pkg::REG_MAP_MODE: cur_mode     = data[0];
			etsa_pkg::REG_GAIN:     cur_gain     = data[6:0];
			etsa_pkg::REG_DECAY:    cur_decay    = data[6:0];
			etsa_pkg::REG_SPAN:     cur_span     = data;
			etsa_pkg::REG_AXIS_MAX: cur_axis_max = data[6:0];
			etsa_pkg::REG_AXIS_MIN: cur_axis_min = data[7:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (delta_queue.size() != 0 || item_valid || expected_axis.size() != 0)
			@(posedge clk);
	endtask

	// item driver: offers queued deltas, predicts each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				expected_axis.push_back(next_axis(delta));
				items_sent++;
			end
			if (!item_valid || item_ready) begin
				if (delta_queue.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
					item_valid <= 1'b1;
					delta      <= delta_queue.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: checks each accepted transaction against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				results_seen++;
				if (expected_axis.size() == 0) begin
					mismatches++;
					$display("%0t: axis_value expected none, got %0d", $time,
						$signed(axis_value));
				end else begin
					want_axis = expected_axis.pop_front();
					if (axis_value !== want_axis) begin
						mismatches++;
						$display("%0t: axis_value expected %0d, got %0d", $time,
							want_axis, $signed(axis_value));
					end
				end
			end
			result_ready <= (hold_left == 0) && (int'($urandom_range(99)) >= stall_pct);
		end
	end

	// hold-off counter
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_seen <= 1'b0;
			hold_left <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= LONG_HOLD;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results outstanding",
				cycles, expected_axis.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int          ph;
		int          k;
		int          r;
		logic        mode;
		logic [6:0]  gain;
		logic [6:0]  decay;
		logic [6:0]  amax;
		logic [7:0]  amin;
		logic [15:0] span;
		logic [15:0] pad;
		logic [15:0] d;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unmapped indexes change nothing
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'h0001);

		// position mode at reset settings: delta extremes and bit patterns
		delta_queue.push_back(16'h0000); delta_queue.push_back(16'h0001);
		delta_queue.push_back(16'hFFFF); delta_queue.push_back(16'h7FFF);
		delta_queue.push_back(16'h8000); delta_queue.push_back(16'h5555);
		delta_queue.push_back(16'hAAAA); delta_queue.push_back(16'h0080);
		delta_queue.push_back(16'hFF80);
		wait_idle();

		// spans too small to scale
		write_reg(etsa_pkg::REG_SPAN, 16'd0);
		delta_queue.push_back(16'h7FFF); delta_queue.push_back(16'h8000);
		wait_idle();
		write_reg(etsa_pkg::REG_SPAN, 16'd1);
		delta_queue.push_back(16'h0003); delta_queue.push_back(16'hFFFE);
		wait_idle();

		// odd span folds residues above span/2 rounded down
		write_reg(etsa_pkg::REG_SPAN, 16'd7);
		delta_queue.push_back(16'h0003); delta_queue.push_back(16'h0001);
		delta_queue.push_back(16'hFFFB);
		wait_idle();

		// zero full scale
		write_reg(etsa_pkg::REG_SPAN, 16'd100);
		write_reg(etsa_pkg::REG_AXIS_MAX, 16'd0);
		delta_queue.push_back(16'h0032); delta_queue.push_back(16'hFFCE);
		wait_idle();

		// velocity mode: clamp both ways, decay to zero from either side
		write_reg(etsa_pkg::REG_AXIS_MAX, 16'd127);
		write_reg(etsa_pkg::REG_GAIN, 16'd127);
		write_reg(etsa_pkg::REG_DECAY, 16'd127);
		write_reg(etsa_pkg::REG_AXIS_MIN, 16'h0080);
		write_reg(etsa_pkg::REG_MAP_MODE, {15'd0, etsa_pkg::MODE_VELOCITY});
		delta_queue.push_back(16'h7FFF); delta_queue.push_back(16'h0000);
		delta_queue.push_back(16'h8000); delta_queue.push_back(16'h0000);
		delta_queue.push_back(16'h0000);
		wait_idle();

		// crossed clamps: lower limit above upper limit
		write_reg(etsa_pkg::REG_GAIN, 16'd1);
		write_reg(etsa_pkg::REG_AXIS_MIN, 16'd40);
		write_reg(etsa_pkg::REG_AXIS_MAX, 16'd10);
		delta_queue.push_back(16'h0005); delta_queue.push_back(16'h0064);
		wait_idle();

		// random phases: modes alternate so state carries across mode changes
		for (ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			mode  = ph[0] ? etsa_pkg::MODE_POSITION : etsa_pkg::MODE_VELOCITY;
			gain  = 7'(pick(0, 127, ph));
			decay = 7'(pick(0, 127, ph));
			amax  = 7'(pick(1, 127, ph));
			amin  = 8'(pick(0, 127, ph) - 128);
			if (ph > 1 && $urandom_range(4) == 0)
				amin = 8'($urandom);
			if (ph == 0) begin
				span = 16'd2;
			end else if (ph == 1) begin
				span = 16'hFFFF;
			end else begin
				case ($urandom_range(7))
					0:       span = 16'd0;
					1:       span = 16'd1;
					2:       span = 16'd3;
					3:       span = 16'hFFFF;
					4, 5:    span = 16'($urandom_range(600, 2));
					default: span = 16'($urandom);
				endcase
			end
			pad = ($urandom_range(1) != 0) ? 16'($urandom) : 16'd0;
			write_reg(etsa_pkg::REG_MAP_MODE, {pad[15:1], mode});
			write_reg(etsa_pkg::REG_GAIN, {pad[15:7], gain});
			write_reg(etsa_pkg::REG_DECAY, {pad[15:7], decay});
			write_reg(etsa_pkg::REG_SPAN, span);
			write_reg(etsa_pkg::REG_AXIS_MAX, {pad[15:7], amax});
			write_reg(etsa_pkg::REG_AXIS_MIN, {pad[15:8], amin});

			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 65; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 65; end
				default: begin send_idle_pct = 21; stall_pct = 21; end
			endcase
			// receiver goes quiet while the sender keeps offering
			if (ph == 3)
				hold_req <= ~hold_req;

			for (k = 0; k < PHASE_ITEMS; k++) begin
				r = int'($urandom_range(9));
				if (r == 9)
					d = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
				else if (r == 8)
					d = 16'($urandom);
				else if (mode == etsa_pkg::MODE_VELOCITY)
					d = (r < 4) ? 16'd0 : 16'($urandom_range(16)) - 16'd8;
				else
					d = (r == 7) ? 16'd0 : 16'($urandom_range(1200)) - 16'd600;
				delta_queue.push_back(d);
			end
		end

		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d deltas over %0d random setting phases plus directed cases,",
			items_sent, N_PHASES);
		$display("both mapping modes; %0d axis values checked, %0d mismatches.",
			results_seen, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
